@@ rtl/sdas_pkg.sv @@
// ----------------------------------------------------------------------------
// sdas_pkg
// Shared types, constants and helper functions for the signed decimal
// adder/subtractor.
// ----------------------------------------------------------------------------
package sdas_pkg;

    // maximum number of digits the datapath supports
    localparam int SDAS_MAX_DIGITS = 15;
    // default digit count
    localparam int SDAS_DIGITS     = 15;
    // packed bcd field width on the ports
    localparam int SDAS_FIELD_W    = 4 * SDAS_MAX_DIGITS;
    // width of the significant digit count
    localparam int SDAS_COUNT_W    = 4;

    // one digit position summed with a possible carry pending, 0..18
    typedef logic [4:0] t_dsum;
    typedef logic [3:0] t_digit;

    // per-lane digit sums for the three candidate operations
    typedef struct packed {
        t_dsum add;   // a + b
        t_dsum ab;    // a + nines(b), carry in 1 gives a - b
        t_dsum ba;    // b + nines(a), carry in 1 gives b - a
    } t_lane_sum;

    // stage enables handed to the merge unit
    typedef struct packed {
        logic en2;
        logic en3;
    } t_merge_ctl;

    // effective operand signs after the operation is folded in
    typedef struct packed {
        logic a_neg;
        logic b_neg;
    } t_sign;

    typedef logic [SDAS_MAX_DIGITS-1:0] t_gp_vec;

    // parallel prefix decimal carry: returns the carry out of every digit
    function automatic t_gp_vec f_carry_prefix(t_gp_vec g, t_gp_vec p, logic cin);
        t_gp_vec gg;
        t_gp_vec pp;
        t_gp_vec gn;
        t_gp_vec pn;
        int      lvl;
        int      i;
        int      d;
        gg    = g;
        pp    = p;
        gg[0] = g[0] | (p[0] & cin);
        for (lvl = 0; lvl < 4; lvl++) begin
            d = 1 << lvl;
            for (i = 0; i < SDAS_MAX_DIGITS; i++) begin
                if (i >= d) begin
                    gn[i] = gg[i] | (pp[i] & gg[i-d]);
                    pn[i] = pp[i] & pp[i-d];
                end else begin
                    gn[i] = gg[i];
                    pn[i] = pp[i];
                end
            end
            gg = gn;
            pp = pn;
        end
        return gg;
    endfunction

    // final decimal digit of a position sum plus its carry in
    function automatic t_digit f_digit_fix(t_dsum s, logic c);
        t_dsum t;
        t = s + {4'd0, c};
        if (t >= 5'd10) begin
            t = t - 5'd10;
        end
        return t[3:0];
    endfunction

endpackage

@@ rtl/sdas_in_if.sv @@
// ----------------------------------------------------------------------------
// sdas_in_if
// Operand channel: operation, two signs and two packed bcd magnitudes.
// ----------------------------------------------------------------------------
interface sdas_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic                            a_negative;
    logic [sdas_pkg::SDAS_FIELD_W-1:0] a_digits;
    logic                            b_negative;
    logic [sdas_pkg::SDAS_FIELD_W-1:0] b_digits;

    modport source (
        output valid, op, a_negative, a_digits, b_negative, b_digits,
        input  ready
    );
    modport sink (
        input  valid, op, a_negative, a_digits, b_negative, b_digits,
        output ready
    );
endinterface

@@ rtl/sdas_out_if.sv @@
// ----------------------------------------------------------------------------
// sdas_out_if
// Result channel: sign, packed bcd magnitude, digit count and overflow.
// ----------------------------------------------------------------------------
interface sdas_out_if;
    logic                              valid;
    logic                              ready;
    logic                              result_negative;
    logic [sdas_pkg::SDAS_FIELD_W-1:0] result_digits;
    logic [sdas_pkg::SDAS_COUNT_W-1:0] digit_count;
    logic                              overflow;

    modport source (
        output valid, result_negative, result_digits, digit_count, overflow,
        input  ready
    );
    modport sink (
        input  valid, result_negative, result_digits, digit_count, overflow,
        output ready
    );
endinterface

@@ rtl/sdas_lane.sv @@
// ----------------------------------------------------------------------------
// sdas_lane
// One digit position: saturates both operand digits and registers the
// position sums for add, a minus b and b minus a.
// ----------------------------------------------------------------------------
module sdas_lane (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [3:0]           i_a_nib,
    input  logic [3:0]           i_b_nib,
    output sdas_pkg::t_lane_sum  o_sum
);
    import sdas_pkg::*;

    t_digit    a_dig;
    t_digit    b_dig;
    t_lane_sum n_sum;
    t_lane_sum r_sum;

    // non-decimal codes read as nine
    assign a_dig = (i_a_nib > 4'd9) ? 4'd9 : i_a_nib;
    assign b_dig = (i_b_nib > 4'd9) ? 4'd9 : i_b_nib;

    // position sums, nines complement for the subtracted operand
    always_comb begin
        n_sum.add = {1'b0, a_dig} + {1'b0, b_dig};
        n_sum.ab  = {1'b0, a_dig} + {1'b0, 4'd9 - b_dig};
        n_sum.ba  = {1'b0, b_dig} + {1'b0, 4'd9 - a_dig};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

@@ rtl/sdas_merge.sv @@
// ----------------------------------------------------------------------------
// sdas_merge
// Combines the lanes: lookahead decimal carries for the three candidate
// sums, picks the one that gives the magnitude, then counts digits.
// ----------------------------------------------------------------------------
module sdas_merge #(
    parameter int DIGITS = sdas_pkg::SDAS_DIGITS
) (
    input  logic                                i_clk,
    input  sdas_pkg::t_merge_ctl                i_ctl,
    input  sdas_pkg::t_sign                     i_sign,
    input  sdas_pkg::t_lane_sum [DIGITS-1:0]    i_sum,
    output logic                                o_negative,
    output logic [sdas_pkg::SDAS_FIELD_W-1:0]   o_digits,
    output logic [sdas_pkg::SDAS_COUNT_W-1:0]   o_count,
    output logic                                o_overflow
);
    import sdas_pkg::*;

    t_gp_vec                 g_add, p_add, g_ab, p_ab, g_ba, p_ba;
    t_gp_vec                 co_add, co_ab, co_ba;
    t_digit [DIGITS-1:0]     d_add, d_ab, d_ba;
    t_digit [DIGITS-1:0]     n_digits;
    t_digit [DIGITS-1:0]     r_digits;
    logic                    same_sign;
    logic                    a_ge_b;
    logic                    n_neg, r_neg;
    logic                    n_ovf, r_ovf;
    logic [DIGITS-1:0]       nz;
    logic [SDAS_FIELD_W-1:0] n_res, r_res;
    logic [SDAS_COUNT_W-1:0] n_cnt, r_cnt;
    logic                    n_neg_out, r_neg_out;
    logic                    r_ovf_out;

    // generate and propagate per digit, unused positions stay zero
    always_comb begin
        g_add = '0; p_add = '0;
        g_ab  = '0; p_ab  = '0;
        g_ba  = '0; p_ba  = '0;
        for (int i = 0; i < DIGITS; i++) begin
            g_add[i] = i_sum[i].add > 5'd9;
            p_add[i] = i_sum[i].add == 5'd9;
            g_ab[i]  = i_sum[i].ab  > 5'd9;
            p_ab[i]  = i_sum[i].ab  == 5'd9;
            g_ba[i]  = i_sum[i].ba  > 5'd9;
            p_ba[i]  = i_sum[i].ba  == 5'd9;
        end
    end

    // carries: plain add, ten's complement subtracts take a carry in of one
    assign co_add = f_carry_prefix(g_add, p_add, 1'b0);
    assign co_ab  = f_carry_prefix(g_ab,  p_ab,  1'b1);
    assign co_ba  = f_carry_prefix(g_ba,  p_ba,  1'b1);

    // result digits of every candidate
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (i == 0) begin
                d_add[i] = f_digit_fix(i_sum[i].add, 1'b0);
                d_ab[i]  = f_digit_fix(i_sum[i].ab,  1'b1);
                d_ba[i]  = f_digit_fix(i_sum[i].ba,  1'b1);
            end else begin
                d_add[i] = f_digit_fix(i_sum[i].add, co_add[i-1]);
                d_ab[i]  = f_digit_fix(i_sum[i].ab,  co_ab[i-1]);
                d_ba[i]  = f_digit_fix(i_sum[i].ba,  co_ba[i-1]);
            end
        end
    end

    // a carry out of a minus b means a is at least b
    assign same_sign = (i_sign.a_neg == i_sign.b_neg);
    assign a_ge_b    = co_ab[DIGITS-1];

    always_comb begin
        if (same_sign) begin
            n_digits = d_add;
            n_neg    = i_sign.a_neg;
            n_ovf    = co_add[DIGITS-1];
        end else if (a_ge_b) begin
            n_digits = d_ab;
            n_neg    = i_sign.a_neg;
            n_ovf    = 1'b0;
        end else begin
            n_digits = d_ba;
            n_neg    = i_sign.b_neg;
            n_ovf    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_digits <= n_digits;
            r_neg    <= n_neg;
            r_ovf    <= n_ovf;
        end
    end

    // significant digit count and zero sign cleanup
    always_comb begin
        n_cnt = SDAS_COUNT_W'(1);
        for (int i = 0; i < DIGITS; i++) begin
            nz[i] = (r_digits[i] != 4'd0);
            if (nz[i]) begin
                n_cnt = SDAS_COUNT_W'(i + 1);
            end
        end
        n_res                 = '0;
        n_res[4*DIGITS-1:0]   = r_digits;
        n_neg_out             = r_neg & ((|nz) | r_ovf);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_res     <= n_res;
            r_cnt     <= n_cnt;
            r_neg_out <= n_neg_out;
            r_ovf_out <= r_ovf;
        end
    end

    assign o_negative = r_neg_out;
    assign o_digits   = r_res;
    assign o_count    = r_cnt;
    assign o_overflow = r_ovf_out;

endmodule

@@ rtl/signed_decimal_add_sub.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_add_sub
// Signed decimal adder/subtractor on sign and packed bcd magnitude words.
// Takes one operand word per clock and returns one result word per clock
// while the result side is ready, through three register stages: the
// per-digit lanes, the lookahead carry and select stage, and the digit
// count stage that doubles as the output register. Ready depends only on
// the fill of those stages and the result side's ready, so a stalled result
// does not block new words while any stage is free. Digits 10 to 15 are
// read as nine, nibbles at and above DIGITS are ignored, a zero result without
// overflow is always positive and overflow keeps the low DIGITS digits.
// ----------------------------------------------------------------------------
module signed_decimal_add_sub #(
    parameter int DIGITS = sdas_pkg::SDAS_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdas_in_if.sink     i_in,
    sdas_out_if.source  o_out
);
    import sdas_pkg::*;

    logic                       en1, en2, en3;
    logic                       r_v1, r_v2, r_v3;
    t_sign                      r_sign;
    t_lane_sum [DIGITS-1:0]     w_sum;
    t_merge_ctl                 ctl;

    // stage enables: a stage moves when it is empty or its successor moves
    assign en3 = !r_v3 || o_out.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_in.ready = en1;
    assign ctl.en2    = en2;
    assign ctl.en3    = en3;

    // valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // subtraction flips the second operand's sign
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_sign.a_neg <= i_in.a_negative;
            r_sign.b_neg <= i_in.b_negative ^ i_in.op;
        end
    end

    // one lane per digit position
    for (genvar k = 0; k < DIGITS; k++) begin : g_lane
        sdas_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en1),
            .i_a_nib (i_in.a_digits[4*k +: 4]),
            .i_b_nib (i_in.b_digits[4*k +: 4]),
            .o_sum   (w_sum[k])
        );
    end

    sdas_merge #(
        .DIGITS (DIGITS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_sign     (r_sign),
        .i_sum      (w_sum),
        .o_negative (o_out.result_negative),
        .o_digits   (o_out.result_digits),
        .o_count    (o_out.digit_count),
        .o_overflow (o_out.overflow)
    );

    assign o_out.valid = r_v3;

    // digit count stays within one and DIGITS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.digit_count >= SDAS_COUNT_W'(1)) &&
                        (o_out.digit_count <= SDAS_COUNT_W'(DIGITS)))
        else $error("digit count out of range");

    // a zero magnitude without overflow is never negative
    a_zero_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.result_digits == '0) && !o_out.overflow
            |-> !o_out.result_negative)
        else $error("negative zero result");

    // nibbles above the digit range are zero
    a_upper_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.result_digits >> (4 * DIGITS)) == '0))
        else $error("result digits above range not clear");

    // a word accepted into an empty pipe shows up at the output through the lane, merge and count registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && !r_v1 && !r_v2 && !r_v3 |-> ##3 o_out.valid)
        else $error("result missing after three cycles");

endmodule
